// ----- sv/sfm_pkg.sv -----
`default_nettype none
package sfm_pkg;

    localparam int SLAVES_PER_GROUP = 8;
    localparam int GROUP_COUNT      = 2;
    localparam int FRAME_BITS       = 18;
    localparam int READ_BITS        = 8;
    localparam int ARRAY_MAX        = 63;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // direction codes
    localparam logic RW_READ  = 1'b0;
    localparam logic RW_WRITE = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic       rw;
        logic       group;
        logic [2:0] chip;
        logic [2:0] chip_addr;
        logic [7:0] reg_array;
        logic [7:0] wdata;
        logic       miso;
    } t_req;

    typedef struct packed {
        logic       pin_group;
        logic       sck;
        logic       mosi;
        logic [7:0] cs_n;
        logic [1:0] reset_pins;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       error;
    } t_res;

    typedef enum logic [13:0] {
        PH_IDLE      = 14'b00000000000001,
        PH_CS_LOW    = 14'b00000000000010,
        PH_MOSI      = 14'b00000000000100,
        PH_SCK_HI    = 14'b00000000001000,
        PH_SCK_LO    = 14'b00000000010000,
        PH_MOSI_ZERO = 14'b00000000100000,
        PH_CS_HIGH   = 14'b00000001000000,
        PH_X_SCK_HI  = 14'b00000010000000,
        PH_X_SCK_LO  = 14'b00000100000000,
        PH_R_CS_LOW  = 14'b00001000000000,
        PH_R_SCK_HI  = 14'b00010000000000,
        PH_R_SCK_LO  = 14'b00100000000000,
        PH_R_SAMPLE  = 14'b01000000000000,
        PH_R_CS_HIGH = 14'b10000000000000
    } t_phase;

endpackage
`default_nettype wire

// ----- sv/spi_frame_master_18bit.sv -----
// channel | direction | handshake         | beat
// in      | input     | valid / stall     | start request or tick (t_req)
// out     | output    | valid / stall     | pin levels and status (t_res)
// cfg     | input     | valid / ready     | chip_reset_level, 2 bits
//
// one beat per clock in and out while the output is not stalled; a result
// passes the input register, then the result register after step logic
// reset is synchronous, active low; the sequence returns to idle, cs high
// a stalled output holds the result and the input register holds one beat,
// so upstream stalls only when both are full
`default_nettype none
module spi_frame_master_18bit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    input  sfm_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output sfm_pkg::t_res o_out_data,
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire [1:0]     i_cfg_data
);
    import sfm_pkg::*;

    logic stage_valid;
    t_req stage_data;
    logic take;

    // input register
    sfm_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_take     (take),
        .o_valid    (stage_valid),
        .o_data     (stage_data)
    );

    // sequencer and result register
    sfm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_req       (stage_data),
        .o_take      (take),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ----- sv/sfm_in_stage.sv -----
`default_nettype none
module sfm_in_stage (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  sfm_pkg::t_req i_in_data,
    input  wire          i_take,
    output logic         o_valid,
    output sfm_pkg::t_req o_data
);
    import sfm_pkg::*;

    logic r_valid;
    logic n_valid;
    t_req r_data;
    logic accept;

    // hold off upstream only while a beat sits here and cannot move on
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ----- sv/sfm_core.sv -----
`default_nettype none
module sfm_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  sfm_pkg::t_req i_req,
    output logic          o_take,
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire [1:0]     i_cfg_data,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output sfm_pkg::t_res o_out_data
);
    import sfm_pkg::*;

    localparam logic [1:0] GROUP_MASK = 2'((1 << GROUP_COUNT) - 1);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_bit_count, n_bit_count;
    logic [17:0] r_frame, n_frame;
    logic [7:0]  r_rshift, n_rshift;
    logic        r_group, n_group;
    logic [2:0]  r_chip, n_chip;
    logic        r_is_read, n_is_read;
    logic        r_sck, n_sck;
    logic        r_mosi, n_mosi;
    logic        r_cs, n_cs;
    logic [1:0]  r_reset_level;
    logic        r_out_valid, n_out_valid;
    t_res        r_out;
    t_res        res;
    logic        fire;
    logic        done, err;
    logic [7:0]  rdata;
    logic [4:0]  bit_inc;
    logic [7:0]  data_byte;

    assign fire        = i_valid && (!r_out_valid || !i_out_stall);
    assign o_take      = fire;
    assign o_cfg_ready = 1'b1;
    assign bit_inc     = r_bit_count + 5'd1;
    assign data_byte   = (i_req.rw == RW_WRITE) ? i_req.wdata : 8'd0;

    // one step of the pin sequence, or a start request checked and loaded
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_frame     = r_frame;
        n_rshift    = r_rshift;
        n_group     = r_group;
        n_chip      = r_chip;
        n_is_read   = r_is_read;
        n_sck       = r_sck;
        n_mosi      = r_mosi;
        n_cs        = r_cs;
        done        = 1'b0;
        err         = 1'b0;
        rdata       = 8'd0;
        if (i_req.req_type == REQ_START) begin
            if (r_phase != PH_IDLE) begin
                err = 1'b1;
            end else if ((i_req.reg_array > 8'(ARRAY_MAX))
                         || (32'(i_req.group) >= 32'(GROUP_COUNT))
                         || (32'(i_req.chip) >= 32'(SLAVES_PER_GROUP))) begin
                err = 1'b1;
            end else begin
                n_frame     = {i_req.chip_addr, i_req.rw, i_req.reg_array[5:0], data_byte};
                n_group     = i_req.group;
                n_chip      = i_req.chip;
                n_is_read   = ~i_req.rw;
                n_bit_count = 5'd0;
                n_rshift    = 8'd0;
                n_sck       = 1'b0;
                n_phase     = PH_CS_LOW;
            end
        end else begin
            unique case (r_phase)
                PH_CS_LOW: begin
                    n_cs        = 1'b0;
                    n_bit_count = 5'd0;
                    n_phase     = PH_MOSI;
                end
                PH_MOSI: begin
                    n_mosi  = r_frame[0];
                    n_phase = PH_SCK_HI;
                end
                PH_SCK_HI: begin
                    n_sck   = 1'b1;
                    n_phase = PH_SCK_LO;
                end
                PH_SCK_LO: begin
                    n_sck       = 1'b0;
                    n_frame     = {1'b0, r_frame[17:1]};
                    n_bit_count = bit_inc;
                    n_phase     = (bit_inc >= 5'(FRAME_BITS)) ? PH_MOSI_ZERO : PH_MOSI;
                end
                PH_MOSI_ZERO: begin
                    n_mosi  = 1'b0;
                    n_phase = PH_CS_HIGH;
                end
                PH_CS_HIGH: begin
                    n_cs = 1'b1;
                    if (r_is_read) begin
                        n_phase = PH_X_SCK_HI;
                    end else begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_X_SCK_HI: begin
                    n_sck   = 1'b1;
                    n_phase = PH_X_SCK_LO;
                end
                PH_X_SCK_LO: begin
                    n_sck   = 1'b0;
                    n_phase = PH_R_CS_LOW;
                end
                PH_R_CS_LOW: begin
                    n_cs        = 1'b0;
                    n_bit_count = 5'd0;
                    n_rshift    = 8'd0;
                    n_phase     = PH_R_SCK_HI;
                end
                PH_R_SCK_HI: begin
                    n_sck   = 1'b1;
                    n_phase = PH_R_SCK_LO;
                end
                PH_R_SCK_LO: begin
                    n_sck   = 1'b0;
                    n_phase = PH_R_SAMPLE;
                end
                PH_R_SAMPLE: begin
                    n_rshift    = r_rshift | (8'(i_req.miso) << r_bit_count[2:0]);
                    n_bit_count = bit_inc;
                    n_phase     = (bit_inc >= 5'(READ_BITS)) ? PH_R_CS_HIGH : PH_R_SCK_HI;
                end
                PH_R_CS_HIGH: begin
                    n_cs    = 1'b1;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    rdata   = r_rshift;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result beat built from the state after the step
    always_comb begin
        res.pin_group = n_group;
        res.sck       = n_sck;
        res.mosi      = n_mosi;
        for (int k = 0; k < 8; k++) begin
            res.cs_n[k] = n_cs || (n_chip != 3'(k)) || (k >= SLAVES_PER_GROUP);
        end
        res.reset_pins = r_reset_level & GROUP_MASK;
        res.busy_res   = (n_phase != PH_IDLE);
        res.done_res   = done;
        res.read_data  = rdata;
        res.error      = err;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // sequence state, config and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= 5'd0;
            r_frame       <= 18'd0;
            r_rshift      <= 8'd0;
            r_group       <= 1'b0;
            r_chip        <= 3'd0;
            r_is_read     <= 1'b0;
            r_sck         <= 1'b0;
            r_mosi        <= 1'b0;
            r_cs          <= 1'b1;
            r_reset_level <= 2'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_frame     <= n_frame;
                r_rshift    <= n_rshift;
                r_group     <= n_group;
                r_chip      <= n_chip;
                r_is_read   <= n_is_read;
                r_sck       <= n_sck;
                r_mosi      <= n_mosi;
                r_cs        <= n_cs;
            end
            if (i_cfg_valid) begin
                r_reset_level <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- sv/sfm_checker.sv -----
`default_nettype none
module sfm_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           o_out_valid,
    input wire           i_out_stall,
    input sfm_pkg::t_res o_out_data
);
    import sfm_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // finishing a transfer leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done with busy still set");

    // a refused request never ends a transfer
    a_err_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> !o_out_data.done_res)
        else $error("error and done together");

    // read data only shows on the done beat
    a_rdata_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.read_data != 8'd0) |-> o_out_data.done_res)
        else $error("read data outside done");

    // at most one chip selected
    a_cs_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(~o_out_data.cs_n))
        else $error("more than one chip select low");
endmodule

bind spi_frame_master_18bit sfm_checker u_sfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
